@@ rtl/serial_escape_mux_top_defines.svh @@
// Assertion macros shared by the serial escape mux RTL
`ifndef SERIAL_ESCAPE_MUX_TOP_DEFINES_SVH
`define SERIAL_ESCAPE_MUX_TOP_DEFINES_SVH

// same-cycle implication, clocked on clk, off during rst
`define SEM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during rst
`define SEM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/sem_pkg.sv @@
// Shared types and constants of the serial escape mux
package sem_pkg;

  typedef enum logic [3:0] {
    KIND_STATUS    = 4'd0,
    KIND_DATA      = 4'd1,
    KIND_FOCUS_OUT = 4'd2,
    KIND_FOCUS_IN  = 4'd3,
    KIND_HELP      = 4'd4,
    KIND_EXIT      = 4'd5,
    KIND_SAVE      = 4'd6,
    KIND_BREAK     = 4'd7,
    KIND_DROP      = 4'd8
  } kind_e;

  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam logic [7:0] CH_QUERY = 8'h3F;
  localparam logic [7:0] CH_HELP  = 8'h68;
  localparam logic [7:0] CH_EXIT  = 8'h78;
  localparam logic [7:0] CH_SAVE  = 8'h73;
  localparam logic [7:0] CH_BREAK = 8'h62;
  localparam logic [7:0] CH_CYCLE = 8'h63;
  localparam logic [7:0] CH_STAMP = 8'h74;

  localparam logic REG_DEVICE_COUNT = 1'b0;
  localparam logic REG_ESCAPE_CHAR  = 1'b1;

  localparam logic [2:0] DEVICE_COUNT_RST = 3'd1;
  localparam logic [7:0] ESCAPE_CHAR_RST  = 8'h01;

  localparam int QUEUE_DEPTH = 2;

  // results that follow the drained bytes of one item, plus per-item flags
  typedef struct packed {
    logic [1:0] n_tail;
    kind_e      kind0;
    logic [1:0] dev0;
    logic [7:0] byte0;
    logic [1:0] dev1;
    logic       can_accept;
    logic [1:0] focus_now;
    logic       stamp;
  } tail_t;

endpackage

@@ rtl/sem_if.sv @@
// Input and result channel interfaces of the serial escape mux
interface sem_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] data_byte;
  logic       sink_ready;

  modport source (output valid, output opcode, output data_byte, output sink_ready,
                  input ready);
  modport sink (input valid, input opcode, input data_byte, input sink_ready,
                output ready);
endinterface

interface sem_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] kind;
  logic [1:0] device;
  logic [7:0] out_byte;
  logic       can_accept;
  logic [1:0] focus_now;
  logic       timestamps_on;
  logic       last;

  modport source (output valid, output kind, output device, output out_byte,
                  output can_accept, output focus_now, output timestamps_on,
                  output last, input ready);
  modport sink (input valid, input kind, input device, input out_byte,
                input can_accept, input focus_now, input timestamps_on,
                input last, output ready);
endinterface

@@ rtl/serial_escape_mux_top.sv @@
// Serial escape mux: one byte stream split among consumer devices, escape commands
// Usage: items enter on rx and results leave on tx, valid/ready on both. An
// item with no buffered bytes to drain yields its one or two results from the
// output register; the input side keeps taking such items while results wait,
// through a two-entry command queue. An item that drains N buffered bytes
// holds them in the back end's ring memory, whose single read port delivers
// one byte per cycle while the output is not stalled, and no further item is
// accepted until the last drained byte has been read. The ring memory has no
// reset and needs no clearing pass; a byte is read only after it was written.
// Registers: device_count at byte address 0, escape_char at byte address 4,
// written through APB.
`include "serial_escape_mux_top_defines.svh"

module serial_escape_mux_top #(
  parameter int DEVICES = 4,
  parameter int BUFFER_DEPTH = 32,
  localparam int DEV_W = (DEVICES > 1) ? $clog2(DEVICES) : 1,
  localparam int IDX_W = $clog2(BUFFER_DEPTH),
  localparam int CNT_W = $clog2(BUFFER_DEPTH + 1),
  localparam int ADDR_W = $clog2(DEVICES * BUFFER_DEPTH),
  localparam int CMD_W = DEV_W + IDX_W + CNT_W + $bits(sem_pkg::tail_t)
) (
  input  logic        clk,
  input  logic        rst,
  sem_in_if.sink      rx,
  sem_out_if.source   tx,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [2:0] device_count;
  logic [7:0] escape_char;

  logic              cmd_push;
  logic              cmd_pop;
  logic              cmd_full;
  logic              cmd_empty;
  logic [CMD_W-1:0]  q_din;
  logic [CMD_W-1:0]  q_dout;
  logic [DEV_W-1:0]  f_dev;
  logic [IDX_W-1:0]  f_idx;
  logic [CNT_W-1:0]  f_cnt;
  sem_pkg::tail_t    f_tail;
  logic [DEV_W-1:0]  b_dev;
  logic [IDX_W-1:0]  b_idx;
  logic [CNT_W-1:0]  b_cnt;
  sem_pkg::tail_t    b_tail;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0]        mem_wdata;
  logic              drain_done;
  logic              back_draining;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_count <= sem_pkg::DEVICE_COUNT_RST;
      escape_char  <= sem_pkg::ESCAPE_CHAR_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        sem_pkg::REG_DEVICE_COUNT: device_count <= pwdata[2:0];
        sem_pkg::REG_ESCAPE_CHAR:  escape_char  <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      sem_pkg::REG_DEVICE_COUNT: prdata = {29'd0, device_count};
      sem_pkg::REG_ESCAPE_CHAR:  prdata = {24'd0, escape_char};
      default:                   prdata = 32'd0;
    endcase
  end

  sem_front #(
    .DEVICES      (DEVICES),
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .device_count (device_count),
    .escape_char  (escape_char),
    .rx           (rx),
    .cmd_full     (cmd_full),
    .cmd_push     (cmd_push),
    .drain_dev    (f_dev),
    .drain_idx    (f_idx),
    .drain_cnt    (f_cnt),
    .tail         (f_tail),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .drain_done   (drain_done)
  );

  assign q_din = {f_dev, f_idx, f_cnt, f_tail};
  assign {b_dev, b_idx, b_cnt, b_tail} = q_dout;

  sem_queue #(
    .WIDTH (CMD_W),
    .DEPTH (sem_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .din   (q_din),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .dout  (q_dout),
    .empty (cmd_empty)
  );

  sem_back #(
    .DEVICES      (DEVICES),
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_empty  (cmd_empty),
    .cmd_pop    (cmd_pop),
    .drain_dev  (b_dev),
    .drain_idx  (b_idx),
    .drain_cnt  (b_cnt),
    .tail       (b_tail),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .drain_done (drain_done),
    .draining   (back_draining),
    .tx         (tx)
  );

  `SEM_ASSERT_SAME(a_no_store_during_drain, mem_we, !back_draining, "ring written while a drain reads it")
  `SEM_ASSERT_SAME(a_status_alone, tx.valid && tx.kind == sem_pkg::KIND_STATUS, tx.last, "status item not last")
  `SEM_ASSERT_NEXT(a_focus_steady, tx.valid && tx.ready && !tx.last, tx.focus_now == $past(tx.focus_now), "focus changed inside one item's results")

endmodule

@@ rtl/sem_queue.sv @@
// Small command FIFO between the classify front and the emit back
module sem_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign dout  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

@@ rtl/sem_front.sv @@
// Front: accepts items, decodes escape commands, keeps focus and ring pointers
module sem_front #(
  parameter int DEVICES = 4,
  parameter int BUFFER_DEPTH = 32,
  localparam int DEV_W  = (DEVICES > 1) ? $clog2(DEVICES) : 1,
  localparam int IDX_W  = $clog2(BUFFER_DEPTH),
  localparam int PTR_W  = IDX_W + 1,
  localparam int CNT_W  = $clog2(BUFFER_DEPTH + 1),
  localparam int ADDR_W = $clog2(DEVICES * BUFFER_DEPTH)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [2:0]         device_count,
  input  logic [7:0]         escape_char,
  sem_in_if.sink             rx,
  input  logic               cmd_full,
  output logic               cmd_push,
  output logic [DEV_W-1:0]   drain_dev,
  output logic [IDX_W-1:0]   drain_idx,
  output logic [CNT_W-1:0]   drain_cnt,
  output sem_pkg::tail_t     tail,
  output logic               mem_we,
  output logic [ADDR_W-1:0]  mem_waddr,
  output logic [7:0]         mem_wdata,
  input  logic               drain_done
);

  logic             escape_pending;
  logic [DEV_W-1:0] focus;
  logic             stamp;
  logic             drain_busy;
  logic [PTR_W-1:0] wptr [DEVICES];
  logic [PTR_W-1:0] rptr [DEVICES];

  logic             acc;
  logic [DEV_W-1:0] m;
  logic [PTR_W-1:0] wm;
  logic [PTR_W-1:0] rm;
  logic [CNT_W-1:0] fill_m;
  logic             full_m;
  logic [DEVICES-1:0] full_cur;
  logic [4:0]       act;
  logic [4:0]       focus_inc;
  logic [PTR_W-1:0] w_next;
  logic [PTR_W-1:0] r_next;
  logic             full_m_after;

  logic             escape_pending_next;
  logic             stamp_next;
  logic [DEV_W-1:0] focus_next;
  logic             do_deliver;
  logic             store;
  logic [1:0]       n_tail;
  sem_pkg::kind_e   kind0;
  logic [1:0]       dev0;
  logic [7:0]       byte0;
  logic [1:0]       dev1;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p[IDX_W-1:0] == IDX_W'(BUFFER_DEPTH - 1)) begin
      ptr_inc = {~p[IDX_W], {IDX_W{1'b0}}};
    end else begin
      ptr_inc = {p[IDX_W], p[IDX_W-1:0] + IDX_W'(1)};
    end
  endfunction

  assign rx.ready = !cmd_full && !drain_busy;
  assign acc      = rx.valid && rx.ready;

  assign m  = (5'(focus) >= 5'(DEVICES)) ? '0 : focus;
  assign wm = wptr[m];
  assign rm = rptr[m];

  assign fill_m = (wm[IDX_W] == rm[IDX_W])
                ? (CNT_W'(wm[IDX_W-1:0]) - CNT_W'(rm[IDX_W-1:0]))
                : (CNT_W'(BUFFER_DEPTH) + CNT_W'(wm[IDX_W-1:0]) - CNT_W'(rm[IDX_W-1:0]));
  assign full_m = (wm[IDX_W-1:0] == rm[IDX_W-1:0]) && (wm[IDX_W] != rm[IDX_W]);

  always_comb begin
    for (int d = 0; d < DEVICES; d++) begin
      full_cur[d] = (wptr[d][IDX_W-1:0] == rptr[d][IDX_W-1:0]) &&
                    (wptr[d][IDX_W] != rptr[d][IDX_W]);
    end
  end

  always_comb begin
    if (device_count == 3'd0) begin
      act = 5'd1;
    end else if (5'(device_count) > 5'(DEVICES)) begin
      act = 5'(DEVICES);
    end else begin
      act = 5'(device_count);
    end
  end

  assign focus_inc = 5'(m) + 5'd1;
  assign drain_cnt = rx.sink_ready ? fill_m : '0;

  always_comb begin
    escape_pending_next = escape_pending;
    stamp_next          = stamp;
    focus_next          = m;
    do_deliver          = 1'b0;
    store               = 1'b0;
    n_tail              = 2'd0;
    kind0               = sem_pkg::KIND_STATUS;
    dev0                = 2'(m);
    byte0               = 8'd0;
    dev1                = 2'd0;
    if (rx.opcode == sem_pkg::OP_BYTE) begin
      if (escape_pending) begin
        escape_pending_next = 1'b0;
        if (rx.data_byte == escape_char) begin
          do_deliver = 1'b1;
        end else begin
          case (rx.data_byte)
            sem_pkg::CH_QUERY, sem_pkg::CH_HELP: begin
              n_tail = 2'd1;
              kind0  = sem_pkg::KIND_HELP;
            end
            sem_pkg::CH_EXIT: begin
              n_tail = 2'd1;
              kind0  = sem_pkg::KIND_EXIT;
            end
            sem_pkg::CH_SAVE: begin
              n_tail = 2'd1;
              kind0  = sem_pkg::KIND_SAVE;
            end
            sem_pkg::CH_BREAK: begin
              n_tail = 2'd1;
              kind0  = sem_pkg::KIND_BREAK;
            end
            sem_pkg::CH_CYCLE: begin
              n_tail     = 2'd2;
              kind0      = sem_pkg::KIND_FOCUS_OUT;
              focus_next = (focus_inc >= act) ? '0 : DEV_W'(focus_inc);
              dev1       = 2'(focus_next);
            end
            sem_pkg::CH_STAMP: begin
              stamp_next = ~stamp;
            end
            default: begin
            end
          endcase
        end
      end else if (rx.data_byte == escape_char) begin
        escape_pending_next = 1'b1;
      end else begin
        do_deliver = 1'b1;
      end
    end
    if (do_deliver) begin
      // ring is empty after the drain whenever the sink is ready
      if (rx.sink_ready) begin
        n_tail = 2'd1;
        kind0  = sem_pkg::KIND_DATA;
        byte0  = rx.data_byte;
      end else if (full_m) begin
        n_tail = 2'd1;
        kind0  = sem_pkg::KIND_DROP;
        byte0  = rx.data_byte;
      end else begin
        store = 1'b1;
      end
    end
    if (n_tail == 2'd0 && drain_cnt == '0) begin
      n_tail = 2'd1;
      kind0  = sem_pkg::KIND_STATUS;
      dev0   = 2'(focus_next);
    end
  end

  assign w_next = store ? ptr_inc(wm) : wm;
  assign r_next = rx.sink_ready ? wm : rm;
  assign full_m_after = (w_next[IDX_W-1:0] == r_next[IDX_W-1:0]) &&
                        (w_next[IDX_W] != r_next[IDX_W]);

  always_comb begin
    tail.n_tail     = n_tail;
    tail.kind0      = kind0;
    tail.dev0       = dev0;
    tail.byte0      = byte0;
    tail.dev1       = dev1;
    tail.can_accept = rx.sink_ready ||
                      !((focus_next == m) ? full_m_after : full_cur[focus_next]);
    tail.focus_now  = 2'(focus_next);
    tail.stamp      = stamp_next;
  end

  assign cmd_push  = acc;
  assign drain_dev = m;
  assign drain_idx = rm[IDX_W-1:0];
  assign mem_we    = acc && store;
  assign mem_waddr = ADDR_W'(m) * ADDR_W'(BUFFER_DEPTH) + ADDR_W'(wm[IDX_W-1:0]);
  assign mem_wdata = rx.data_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_pending <= 1'b0;
      focus          <= '0;
      stamp          <= 1'b0;
      drain_busy     <= 1'b0;
      for (int d = 0; d < DEVICES; d++) begin
        wptr[d] <= '0;
        rptr[d] <= '0;
      end
    end else begin
      if (drain_done) begin
        drain_busy <= 1'b0;
      end else if (acc && drain_cnt != '0) begin
        drain_busy <= 1'b1;
      end
      if (acc) begin
        escape_pending <= escape_pending_next;
        stamp          <= stamp_next;
        focus          <= focus_next;
        wptr[m]        <= w_next;
        rptr[m]        <= r_next;
      end
    end
  end

endmodule

@@ rtl/sem_back.sv @@
// Back: holds the ring memory, walks drains and emits result items
module sem_back #(
  parameter int DEVICES = 4,
  parameter int BUFFER_DEPTH = 32,
  localparam int DEV_W  = (DEVICES > 1) ? $clog2(DEVICES) : 1,
  localparam int IDX_W  = $clog2(BUFFER_DEPTH),
  localparam int CNT_W  = $clog2(BUFFER_DEPTH + 1),
  localparam int ADDR_W = $clog2(DEVICES * BUFFER_DEPTH)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_empty,
  output logic              cmd_pop,
  input  logic [DEV_W-1:0]  drain_dev,
  input  logic [IDX_W-1:0]  drain_idx,
  input  logic [CNT_W-1:0]  drain_cnt,
  input  sem_pkg::tail_t    tail,
  input  logic              mem_we,
  input  logic [ADDR_W-1:0] mem_waddr,
  input  logic [7:0]        mem_wdata,
  output logic              drain_done,
  output logic              draining,
  sem_out_if.source         tx
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_LOAD = 4'b0100,
    ST_TAIL = 4'b1000
  } state_t;

  state_t           state;
  logic [7:0]       ring_mem [DEVICES * BUFFER_DEPTH];
  logic [7:0]       mem_q;
  logic [DEV_W-1:0] dev_r;
  logic [IDX_W-1:0] idx_r;
  logic [CNT_W-1:0] cnt_r;
  sem_pkg::tail_t   tail_r;
  logic             tail_sel;

  logic             o_valid;
  sem_pkg::kind_e   o_kind;
  logic [1:0]       o_dev;
  logic [7:0]       o_byte;
  logic             o_can;
  logic [1:0]       o_focus;
  logic             o_stamp;
  logic             o_last;

  logic              slot_free;
  logic              out_load;
  logic              rd_en;
  logic [ADDR_W-1:0] raddr;
  logic [IDX_W-1:0]  idx_inc;
  logic              last_byte;

  assign slot_free = !o_valid || tx.ready;
  assign out_load  = slot_free && ((state == ST_LOAD) || (state == ST_TAIL));
  assign last_byte = (cnt_r == CNT_W'(1));
  assign idx_inc   = (idx_r == IDX_W'(BUFFER_DEPTH - 1)) ? '0 : idx_r + IDX_W'(1);
  assign raddr     = ADDR_W'(dev_r) * ADDR_W'(BUFFER_DEPTH) + ADDR_W'(idx_r);
  assign rd_en     = (state == ST_READ) ||
                     (state == ST_LOAD && slot_free && !last_byte);
  assign drain_done = (state == ST_LOAD) && slot_free && last_byte;
  assign draining   = (state == ST_READ) || (state == ST_LOAD);
  assign cmd_pop    = (state == ST_IDLE) && !cmd_empty;

  assign tx.valid         = o_valid;
  assign tx.kind          = o_kind;
  assign tx.device        = o_dev;
  assign tx.out_byte      = o_byte;
  assign tx.can_accept    = o_can;
  assign tx.focus_now     = o_focus;
  assign tx.timestamps_on = o_stamp;
  assign tx.last          = o_last;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      mem_q <= ring_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      o_valid <= 1'b0;
    end else begin
      if (out_load) begin
        o_valid <= 1'b1;
      end else if (tx.ready) begin
        o_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (!cmd_empty) begin
            dev_r    <= drain_dev;
            idx_r    <= drain_idx;
            cnt_r    <= drain_cnt;
            tail_r   <= tail;
            tail_sel <= 1'b0;
            state    <= (drain_cnt != '0) ? ST_READ : ST_TAIL;
          end
        end
        ST_READ: begin
          idx_r <= idx_inc;
          state <= ST_LOAD;
        end
        ST_LOAD: begin
          if (slot_free) begin
            o_kind  <= sem_pkg::KIND_DATA;
            o_dev   <= 2'(dev_r);
            o_byte  <= mem_q;
            o_can   <= tail_r.can_accept;
            o_focus <= tail_r.focus_now;
            o_stamp <= tail_r.stamp;
            o_last  <= last_byte && (tail_r.n_tail == 2'd0);
            cnt_r   <= cnt_r - CNT_W'(1);
            if (last_byte) begin
              state <= (tail_r.n_tail != 2'd0) ? ST_TAIL : ST_IDLE;
            end else begin
              idx_r <= idx_inc;
            end
          end
        end
        ST_TAIL: begin
          if (slot_free) begin
            o_can   <= tail_r.can_accept;
            o_focus <= tail_r.focus_now;
            o_stamp <= tail_r.stamp;
            if (!tail_sel) begin
              o_kind <= tail_r.kind0;
              o_dev  <= tail_r.dev0;
              o_byte <= tail_r.byte0;
              o_last <= (tail_r.n_tail == 2'd1);
              if (tail_r.n_tail == 2'd1) begin
                state <= ST_IDLE;
              end else begin
                tail_sel <= 1'b1;
              end
            end else begin
              o_kind <= sem_pkg::KIND_FOCUS_IN;
              o_dev  <= tail_r.dev1;
              o_byte <= 8'd0;
              o_last <= 1'b1;
              state  <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ verif/tb_serial_escape_mux_top.sv @@
// Self-checking testbench for the serial escape mux: byte routing, escape commands, ring overflow
`timescale 1ns / 1ps
module tb_serial_escape_mux_top;

  localparam int DEVS = 4;
  localparam int RING_DEPTH = 32;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    sem_pkg::kind_e kind;
    logic [1:0]     device;
    logic [7:0]     out_byte;
    logic           can_accept;
    logic [1:0]     focus_now;
    logic           stamp;
    logic           last;
  } mux_result_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  sem_in_if  rx_bus();
  sem_out_if tx_bus();

  serial_escape_mux_top dut (
    .clk     (clk),
    .rst     (rst),
    .rx      (rx_bus),
    .tx      (tx_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // mux state mirror
  logic [2:0]  dev_count_reg;
  logic [7:0]  escape_reg;
  logic        escape_armed;
  logic [1:0]  focus_dev;
  logic        stamp_on;
  logic [7:0]  ring_mem [DEVS][RING_DEPTH];
  logic [5:0]  wr_ptr [DEVS];
  logic [5:0]  rd_ptr [DEVS];

  mux_result_t expected_results[$];
  mux_result_t step_results[$];
  mux_result_t oldest;

  bit steady_flow;
  int mismatch_count;
  int items_accepted;
  int results_checked;
  int drops_predicted;
  int config_writes;
  int idle_cycles;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic logic [5:0] ring_fill(int m);
    return wr_ptr[m] - rd_ptr[m];
  endfunction

  function automatic int active_devices();
    if (dev_count_reg == 3'd0) return 1;
    if (dev_count_reg > DEVS) return DEVS;
    return dev_count_reg;
  endfunction

  function automatic void add_result(sem_pkg::kind_e kind, int dev, logic [7:0] b);
    mux_result_t r;
    r = '0;
    r.kind = kind;
    r.device = dev[1:0];
    r.out_byte = b;
    step_results.push_back(r);
    if (kind == sem_pkg::KIND_DROP) drops_predicted++;
  endfunction

  function automatic void route_byte(int m, logic [7:0] b, logic rdy);
    if (ring_fill(m) == 6'd0 && rdy) begin
      add_result(sem_pkg::KIND_DATA, m, b);
    end else if (ring_fill(m) >= RING_DEPTH) begin
      add_result(sem_pkg::KIND_DROP, m, b);
    end else begin
      ring_mem[m][wr_ptr[m][4:0]] = b;
      wr_ptr[m] = wr_ptr[m] + 6'd1;
    end
  endfunction

  function automatic void predict_item(logic op, logic [7:0] ch, logic rdy);
    int m;
    int nxt;
    mux_result_t r;
    step_results.delete();
    m = focus_dev;
    while (rdy && ring_fill(m) != 6'd0) begin
      add_result(sem_pkg::KIND_DATA, m, ring_mem[m][rd_ptr[m][4:0]]);
      rd_ptr[m] = rd_ptr[m] + 6'd1;
    end
    if (op == sem_pkg::OP_BYTE) begin
      if (escape_armed) begin
        escape_armed = 1'b0;
        if (ch == escape_reg) begin
          route_byte(m, ch, rdy);
        end else if (ch == sem_pkg::CH_QUERY || ch == sem_pkg::CH_HELP) begin
          add_result(sem_pkg::KIND_HELP, m, 8'h00);
        end else if (ch == sem_pkg::CH_EXIT) begin
          add_result(sem_pkg::KIND_EXIT, m, 8'h00);
        end else if (ch == sem_pkg::CH_SAVE) begin
          add_result(sem_pkg::KIND_SAVE, m, 8'h00);
        end else if (ch == sem_pkg::CH_BREAK) begin
          add_result(sem_pkg::KIND_BREAK, m, 8'h00);
        end else if (ch == sem_pkg::CH_CYCLE) begin
          add_result(sem_pkg::KIND_FOCUS_OUT, m, 8'h00);
          nxt = m + 1;
          if (nxt >= active_devices()) nxt = 0;
          focus_dev = nxt[1:0];
          add_result(sem_pkg::KIND_FOCUS_IN, nxt, 8'h00);
        end else if (ch == sem_pkg::CH_STAMP) begin
          stamp_on = ~stamp_on;
        end
      end else if (ch == escape_reg) begin
        escape_armed = 1'b1;
      end else begin
        route_byte(m, ch, rdy);
      end
    end
    if (step_results.size() == 0) add_result(sem_pkg::KIND_STATUS, focus_dev, 8'h00);
    foreach (step_results[k]) begin
      r = step_results[k];
      r.can_accept = (ring_fill(focus_dev) < RING_DEPTH) || rdy;
      r.focus_now = focus_dev;
      r.stamp = stamp_on;
      r.last = (k == step_results.size() - 1);
      expected_results.push_back(r);
    end
  endfunction

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (rx_bus.valid && rx_bus.ready) begin
        predict_item(rx_bus.opcode, rx_bus.data_byte, rx_bus.sink_ready);
        items_accepted++;
      end
      if (tx_bus.valid && tx_bus.ready) begin
        if (expected_results.size() == 0) begin
          $error("result with none expected: kind %0d device %0d byte 0x%0h",
                 tx_bus.kind, tx_bus.device, tx_bus.out_byte);
          mismatch_count++;
        end else begin
          oldest = expected_results.pop_front();
          check_field("kind", oldest.kind, tx_bus.kind);
          check_field("device", oldest.device, tx_bus.device);
          check_field("out_byte", oldest.out_byte, tx_bus.out_byte);
          check_field("can_accept", oldest.can_accept, tx_bus.can_accept);
          check_field("focus_now", oldest.focus_now, tx_bus.focus_now);
          check_field("timestamps_on", oldest.stamp, tx_bus.timestamps_on);
          check_field("last", oldest.last, tx_bus.last);
          results_checked++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (rx_bus.valid && rx_bus.ready) || (tx_bus.valid && tx_bus.ready) ||
        (psel && penable && pwrite && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (steady_flow) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic ready_bit(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic logic [7:0] pick_command();
    case ($urandom_range(0, 9))
      0: return sem_pkg::CH_QUERY;
      1: return sem_pkg::CH_HELP;
      2: return sem_pkg::CH_EXIT;
      3: return sem_pkg::CH_SAVE;
      4: return sem_pkg::CH_BREAK;
      5, 6: return sem_pkg::CH_CYCLE;
      7: return sem_pkg::CH_STAMP;
      8: return escape_reg;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin : result_stalls
    int hold;
    tx_bus.ready <= 1'b0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        tx_bus.ready <= 1'b0;
        hold--;
      end else begin
        tx_bus.ready <= 1'b1;
        hold = pick_gap();
      end
    end
  end

  task automatic send_item(logic op, logic [7:0] b, logic rdy);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      rx_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_bus.valid <= 1'b1;
    rx_bus.opcode <= op;
    rx_bus.data_byte <= b;
    rx_bus.sink_ready <= rdy;
    do @(posedge clk); while (!rx_bus.ready);
  endtask

  task automatic send_command(logic [7:0] cmd, logic rdy);
    send_item(sem_pkg::OP_BYTE, escape_reg, rdy);
    send_item(sem_pkg::OP_BYTE, cmd, rdy);
  endtask

  task automatic wait_quiet();
    rx_bus.valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [7:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {24'h0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == sem_pkg::REG_DEVICE_COUNT) dev_count_reg = value[2:0];
    else escape_reg = value;
    config_writes++;
    @(posedge clk);
  endtask

  task automatic test_plain_bytes();
    send_item(sem_pkg::OP_BYTE, 8'h00, 1'b1);
    send_item(sem_pkg::OP_BYTE, 8'hFF, 1'b0);
    send_item(sem_pkg::OP_BYTE, 8'h5A, 1'b1);
    send_item(sem_pkg::OP_DRAIN, 8'hA5, 1'b1);
    send_item(sem_pkg::OP_BYTE, 8'h33, 1'b0);
    send_item(sem_pkg::OP_DRAIN, 8'h00, 1'b0);
    send_item(sem_pkg::OP_DRAIN, 8'hFF, 1'b1);
  endtask

  task automatic test_commands();
    logic [7:0] cmds [10];
    cmds = '{sem_pkg::CH_QUERY, sem_pkg::CH_HELP, sem_pkg::CH_EXIT, sem_pkg::CH_SAVE,
             sem_pkg::CH_BREAK, sem_pkg::CH_STAMP, sem_pkg::CH_STAMP, sem_pkg::CH_CYCLE,
             8'h00, 8'h7A};
    cmds[8] = escape_reg;
    foreach (cmds[i]) send_command(cmds[i], 1'($urandom_range(0, 1)));
  endtask

  task automatic test_focus_rotation();
    wait_quiet();
    write_reg(sem_pkg::REG_DEVICE_COUNT, 8'd4);
    write_reg(sem_pkg::REG_ESCAPE_CHAR, 8'hFF);
    repeat (3) send_command(sem_pkg::CH_CYCLE, 1'b1);
    send_item(sem_pkg::OP_BYTE, 8'h81, 1'b0);
    // focus 3 survives a lower count until the next rotate
    wait_quiet();
    write_reg(sem_pkg::REG_DEVICE_COUNT, 8'd2);
    send_item(sem_pkg::OP_BYTE, 8'h42, 1'b1);
    send_command(sem_pkg::CH_CYCLE, 1'b0);
    wait_quiet();
    write_reg(sem_pkg::REG_DEVICE_COUNT, 8'd0);
    send_command(sem_pkg::CH_CYCLE, 1'b1);
    wait_quiet();
    write_reg(sem_pkg::REG_DEVICE_COUNT, 8'd7);
    send_command(sem_pkg::CH_CYCLE, 1'b1);
  endtask

  task automatic test_escape_values();
    wait_quiet();
    write_reg(sem_pkg::REG_ESCAPE_CHAR, sem_pkg::CH_CYCLE);
    send_command(sem_pkg::CH_CYCLE, 1'b1);
    send_command(sem_pkg::CH_STAMP, 1'b1);
    wait_quiet();
    write_reg(sem_pkg::REG_ESCAPE_CHAR, 8'h00);
    send_command(8'h00, 1'b0);
    send_item(sem_pkg::OP_DRAIN, 8'h00, 1'b1);
  endtask

  task automatic test_ring_overflow();
    wait_quiet();
    write_reg(sem_pkg::REG_DEVICE_COUNT, 8'd4);
    write_reg(sem_pkg::REG_ESCAPE_CHAR, 8'h1B);
    for (int i = 0; i < RING_DEPTH + 2; i++) begin
      send_item(sem_pkg::OP_BYTE, 8'h20 + 8'(i), 1'b0);
    end
    send_command(8'h1B, 1'b0);
    // full ring drains ahead of the focus events: largest result burst
    send_item(sem_pkg::OP_BYTE, 8'h1B, 1'b0);
    send_item(sem_pkg::OP_BYTE, sem_pkg::CH_CYCLE, 1'b1);
  endtask

  task automatic test_random_traffic();
    int sent;
    int pct_ready;
    int r;
    for (int phase = 0; phase < 4; phase++) begin
      wait_quiet();
      case (phase)
        0: begin
          write_reg(sem_pkg::REG_DEVICE_COUNT, 8'd4);
          write_reg(sem_pkg::REG_ESCAPE_CHAR, 8'hFF);
        end
        1: begin
          write_reg(sem_pkg::REG_DEVICE_COUNT, 8'd1);
          write_reg(sem_pkg::REG_ESCAPE_CHAR, 8'h00);
        end
        default: begin
          write_reg(sem_pkg::REG_DEVICE_COUNT, 8'($urandom_range(0, 7)));
          write_reg(sem_pkg::REG_ESCAPE_CHAR, 8'($urandom_range(0, 255)));
        end
      endcase
      steady_flow = (phase == 2);
      pct_ready = $urandom_range(10, 90);
      sent = 0;
      while (sent < 16) begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          send_item(sem_pkg::OP_BYTE, 8'($urandom_range(0, 255)), ready_bit(pct_ready));
          sent++;
        end else if (r < 75) begin
          send_command(pick_command(), ready_bit(pct_ready));
          sent += 2;
        end else if (r < 90) begin
          send_item(sem_pkg::OP_DRAIN, 8'($urandom_range(0, 255)), ready_bit(pct_ready));
          sent++;
        end else begin
          send_item(sem_pkg::OP_BYTE, escape_reg, ready_bit(pct_ready));
          sent++;
        end
      end
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    rx_bus.valid <= 1'b0;
    rx_bus.opcode <= sem_pkg::OP_BYTE;
    rx_bus.data_byte <= 8'h00;
    rx_bus.sink_ready <= 1'b0;
    dev_count_reg = sem_pkg::DEVICE_COUNT_RST;
    escape_reg = sem_pkg::ESCAPE_CHAR_RST;
    escape_armed = 1'b0;
    focus_dev = 2'd0;
    stamp_on = 1'b0;
    for (int d = 0; d < DEVS; d++) begin
      wr_ptr[d] = 6'd0;
      rd_ptr[d] = 6'd0;
    end
    steady_flow = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_plain_bytes();
    test_commands();
    test_focus_rotation();
    test_escape_values();
    test_ring_overflow();
    test_random_traffic();

    wait_quiet();
    repeat (16) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      mismatch_count++;
    end
    $display("Covered %0d items and %0d results across %0d register writes,",
             items_accepted, results_checked, config_writes);
    $display("including %0d overflow drops and all escape commands.", drops_predicted);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/sem_pkg.sv
rtl/sem_if.sv
rtl/sem_queue.sv
rtl/sem_front.sv
rtl/sem_back.sv
rtl/serial_escape_mux_top.sv
verif/tb_serial_escape_mux_top.sv
